// ----- rtl/qsbs_pkg.sv -----
// qsbs_pkg: shared constants and types of the quicksort block sorter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package qsbs_pkg;

    // capacity of the cell row, one stored word per cell
    localparam int MAX_ITEMS = 64;
    localparam int VALUE_W   = 32;
    // count must reach MAX_ITEMS itself
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [CNT_W-1:0]          t_count;

    typedef enum logic {
        ST_LOAD,
        ST_UNLOAD
    } t_state;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic insert;   // place the incoming word into the row
        logic shift;    // move the row one cell toward the output
    } t_cell_cmd;

endpackage

// ----- rtl/quicksort_block_sorter.sv -----
// quicksort_block_sorter: top level, a row of sorting cells and its sequencer
// depends on qsbs_pkg, qsbs_cell, qsbs_ctrl
`timescale 1ns / 1ps

// Block sorter for signed 32-bit words. Words arrive on the input channel
// and are kept in ascending order in a row of MAX_ITEMS cells as they come
// in: every cell compares the incoming word with its own and the row opens
// a gap at the insertion point, so each word is placed as it is taken and no
// separate sort pass follows. The word flagged last_item closes the block;
// the input then stops taking words and the row streams the block out
// smallest first, one word per cycle while i_ready is high, cell 0 serving
// as the output register. The row never inserts and shifts at once. Equal
// words come out in any order, which is invisible since they are
// bit-identical. Words offered while the row is full are dropped and every
// output word of that block carries overflowed; a last word that is
// dropped still closes the block. end_of_block marks the final word.
// Output never overlaps input: loading and unloading alternate.

module quicksort_block_sorter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input channel
    input  logic             i_valid,
    output logic             o_ready,
    input  qsbs_pkg::t_value i_value,
    input  logic             i_last_item,
    // output channel
    output logic             o_valid,
    input  logic             i_ready,
    output qsbs_pkg::t_value o_sorted_value,
    output logic             o_end_of_block,
    output logic             o_overflowed
);
    import qsbs_pkg::*;

    t_cell_cmd w_cmd;
    t_value    w_cell_value [MAX_ITEMS];
    logic      w_cell_valid [MAX_ITEMS];
    logic      w_cell_gt    [MAX_ITEMS];

    // sequencer: fill count, overflow flag, load or unload phase
    qsbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_last      (i_last_item),
        .i_out_ready (i_ready),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_eob       (o_end_of_block),
        .o_ovf       (o_overflowed),
        .o_cmd       (w_cmd)
    );

    // the row: cell 0 holds the smallest word, empty cells sit at the far end
    for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
        t_value w_left_value;
        logic   w_left_valid;
        logic   w_left_gt;
        t_value w_right_value;
        logic   w_right_valid;

        if (k == 0) begin : g_head
            // nothing to the left: the insertion point can be no further
            assign w_left_value = '0;
            assign w_left_valid = 1'b0;
            assign w_left_gt    = 1'b0;
        end else begin : g_body
            assign w_left_value = w_cell_value[k-1];
            assign w_left_valid = w_cell_valid[k-1];
            assign w_left_gt    = w_cell_gt[k-1];
        end

        if (k == MAX_ITEMS - 1) begin : g_tail
            // the far end fills with empty cells while unloading
            assign w_right_value = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_inner
            assign w_right_value = w_cell_value[k+1];
            assign w_right_valid = w_cell_valid[k+1];
        end

        qsbs_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_ins_value   (i_value),
            .i_left_value  (w_left_value),
            .i_left_valid  (w_left_valid),
            .i_left_gt     (w_left_gt),
            .i_right_value (w_right_value),
            .i_right_valid (w_right_valid),
            .o_value       (w_cell_value[k]),
            .o_valid       (w_cell_valid[k]),
            .o_gt          (w_cell_gt[k])
        );
    end

    // head cell is the output register
    assign o_sorted_value = w_cell_value[0];

endmodule

// ----- rtl/qsbs_cell.sv -----
// qsbs_cell: one cell of the sorting row, holds one word and its valid bit
// depends on qsbs_pkg
`timescale 1ns / 1ps

module qsbs_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qsbs_pkg::t_cell_cmd i_cmd,
    input  qsbs_pkg::t_value   i_ins_value,
    input  qsbs_pkg::t_value   i_left_value,
    input  logic               i_left_valid,
    input  logic               i_left_gt,
    input  qsbs_pkg::t_value   i_right_value,
    input  logic               i_right_valid,
    output qsbs_pkg::t_value   o_value,
    output logic               o_valid,
    output logic               o_gt
);
    import qsbs_pkg::*;

    t_value r_value;
    t_value n_value;
    logic   r_valid;
    logic   n_valid;
    logic   w_gt;

    // an empty cell acts as plus infinity
    assign w_gt = !r_valid || (r_value > i_ins_value);

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_cmd.shift) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end else if (i_cmd.insert && w_gt) begin
            if (i_left_gt) begin
                // insertion point lies to the left: take the neighbor's word
                n_value = i_left_value;
                n_valid = i_left_valid;
            end else begin
                n_value = i_ins_value;
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_value = r_value;
    assign o_valid = r_valid;
    assign o_gt    = w_gt;

endmodule

// ----- rtl/qsbs_ctrl.sv -----
// qsbs_ctrl: load / unload sequencer, fill count and overflow flag
// depends on qsbs_pkg
`timescale 1ns / 1ps

module qsbs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_last,
    input  logic                i_out_ready,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output logic                o_eob,
    output logic                o_ovf,
    output qsbs_pkg::t_cell_cmd o_cmd
);
    import qsbs_pkg::*;

    t_state r_state;
    t_state n_state;
    t_count r_count;
    t_count n_count;
    logic   r_ovf;
    logic   n_ovf;
    logic   w_in_acc;
    logic   w_out_acc;
    logic   w_full;
    logic   w_one_left;

    assign w_full     = (r_count == t_count'(MAX_ITEMS));
    assign w_one_left = (r_count == t_count'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (i_in_valid && i_last) begin
                    n_state = ST_UNLOAD;
                end
            end
            ST_UNLOAD: begin
                if (i_out_ready && w_one_left) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_LOAD:   o_in_ready  = 1'b1;
            ST_UNLOAD: o_out_valid = 1'b1;
            default: begin
                o_in_ready  = 1'b0;
                o_out_valid = 1'b0;
            end
        endcase
    end

    assign w_in_acc     = o_in_ready && i_in_valid;
    assign w_out_acc    = o_out_valid && i_out_ready;
    assign o_cmd.insert = w_in_acc && !w_full;
    assign o_cmd.shift  = w_out_acc;
    assign o_eob        = w_one_left;
    assign o_ovf        = r_ovf;

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (o_cmd.insert) begin
            n_count = r_count + t_count'(1);
        end else if (w_out_acc) begin
            n_count = r_count - t_count'(1);
        end
        if (w_in_acc && w_full) begin
            n_ovf = 1'b1;
        end else if (w_out_acc && w_one_left) begin
            n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

endmodule

// ----- rtl/qsbs_checker.sv -----
// qsbs_checker: port-level assertions for quicksort_block_sorter
// depends on qsbs_pkg; attached to the top level by the bind below
`timescale 1ns / 1ps

module qsbs_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input logic             i_last_item,
    input logic             o_valid,
    input logic             i_ready,
    input qsbs_pkg::t_value o_sorted_value,
    input logic             o_end_of_block,
    input logic             o_overflowed
);
    import qsbs_pkg::*;

    // load and unload phases never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input and output open at the same time");

    // a closing word starts the unload right away
    a_last_starts_unload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_last_item) |=> o_valid)
        else $error("no output after the last word");

    // a block keeps streaming with one overflow flag until its final word
    a_block_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_end_of_block) |=> (o_valid && $stable(o_overflowed)))
        else $error("block stream broken before its end");

    // the final word returns the block to loading
    a_block_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_end_of_block) |=> (!o_valid && o_ready))
        else $error("block did not end after its final word");

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_sorted_value)))
        else $error("output word changed while stalled");

endmodule

bind quicksort_block_sorter qsbs_checker u_qsbs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .i_last_item    (i_last_item),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_sorted_value (o_sorted_value),
    .o_end_of_block (o_end_of_block),
    .o_overflowed   (o_overflowed)
);
